// ----- hdl/hfti_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the height-field triangle interpolator.
// No dependencies; imported by the top level and hfti_split.
package hfti_pkg;

  localparam int unsigned HEIGHT_W    = 24;
  localparam int unsigned STORE_AW    = 16;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned SAMPLE_W    = 8;

  // Division by 255 is done as two radix-2^16 digits, each by reciprocal multiplication.
  // The first digit's dividend is below 2^17, the second's below 2^24.
  localparam int unsigned DIV_A_SHIFT = 25;
  localparam int unsigned DIV_B_SHIFT = 32;
  localparam logic [63:0] DIV_A_RECIP = ((64'd1 << DIV_A_SHIFT) + 64'd254) / 64'd255;
  localparam logic [63:0] DIV_B_RECIP = ((64'd1 << DIV_B_SHIFT) + 64'd254) / 64'd255;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_MIN_HEIGHT = 2'd0,
    CFG_MAX_HEIGHT = 2'd1,
    CFG_TILE_COL   = 2'd2,
    CFG_TILE_ROW   = 2'd3
  } cfg_idx_e;

endpackage

// ----- hdl/heightfield_triangle_interpolator.sv -----
`timescale 1ns / 1ps
// Top level of the height-field triangle interpolator.
// Depends on hfti_pkg, hfti_split (coordinate split) and hfti_ram (sample store copies).
//
// Usage:
//   Input beats arrive on the s_axis group. A write beat (opcode = write) loads one
//   map byte into the sample store and yields no output beat. A query beat yields
//   exactly one output beat on the m_axis group with the saturated Q15.8 height and
//   a flag telling whether the upper triangle of the cell was used.
//   Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the block is idle; each write takes effect at that clock edge.
//   Throughput is one beat per cycle for any mix of writes and queries unless stalled.
//   A query's result reaches m_axis through the pipeline's 14 register stages
//   (five split stages, the store read, interpolation, scaling and the two-digit
//   division by 255, and the output).
//   The four cell corners are read from four copies of the sample store, so all
//   corners are read in the same cycle. Writes update all copies in the same stage
//   where queries read, which keeps reads and writes in arrival order.
//   The whole pipeline advances only when the output register is empty or taken,
//   so a stalled receiver freezes every stage and s_axis_tready falls with it.
//   Reset clears the valid bits and loads the register defaults; the store
//   contents are undefined until written.
module heightfield_triangle_interpolator
  import hfti_pkg::*;
#(
  parameter int unsigned EDGE_SAMPLES = 256,
  parameter int unsigned TILE_SIZE    = 1024,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_index[15:0], sample_value[23:16], pos_x[55:24], pos_z[87:56]
  input  logic [87:0] s_axis_tdata,
  // opcode[0], world_coords[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // height[23:0]
  output logic [23:0] m_axis_tdata,
  // upper_triangle[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam int unsigned LE = $clog2(EDGE_SAMPLES);
  localparam int unsigned BW = 2 * LE + 1;
  localparam int unsigned FB = FRAC_BITS;
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;
  localparam logic [FB+32:0] HALF_DEN = (FB+33)'(255) << (FB - 1);

  // Configuration registers.
  logic signed [HEIGHT_W-1:0] min_q, max_q;
  logic signed [5:0]          tile_col_q, tile_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= '0;
      max_q      <= 24'sd25600;
      tile_col_q <= '0;
      tile_row_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_HEIGHT: min_q      <= cfg_wdata_i;
        CFG_MAX_HEIGHT: max_q      <= cfg_wdata_i;
        CFG_TILE_COL:   tile_col_q <= cfg_wdata_i[5:0];
        CFG_TILE_ROW:   tile_row_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Every stage moves when the output register is free or being drained.
  logic en;
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [13:1] v_q;
  opcode_e     op_q  [1:5];
  logic [15:0] idx_q [1:5];
  logic [7:0]  val_q [1:5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q[1]     <= s_axis_tvalid;
      v_q[5:2]   <= v_q[4:1];
      v_q[6]     <= v_q[5] && (op_q[5] == OP_QUERY);
      v_q[13:7]  <= v_q[12:6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[1]  <= opcode_e'(s_axis_tuser[0]);
      idx_q[1] <= s_axis_tdata[15:0];
      val_q[1] <= s_axis_tdata[23:16];
      for (int k = 2; k <= 5; k++) begin
        op_q[k]  <= op_q[k-1];
        idx_q[k] <= idx_q[k-1];
        val_q[k] <= val_q[k-1];
      end
    end
  end

  // Cell and fraction along each axis, valid alongside stage 5.
  logic [LE-1:0] cx, cz;
  logic [FB-1:0] fx, fz;

  hfti_split #(
    .EDGE_SAMPLES(EDGE_SAMPLES),
    .TILE_SIZE   (TILE_SIZE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_split_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .pos_i  (s_axis_tdata[55:24]),
    .world_i(s_axis_tuser[1]),
    .tile_i (tile_col_q),
    .cell_o (cx),
    .frac_o (fx)
  );

  hfti_split #(
    .EDGE_SAMPLES(EDGE_SAMPLES),
    .TILE_SIZE   (TILE_SIZE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_split_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .pos_i  (s_axis_tdata[87:56]),
    .world_i(s_axis_tuser[1]),
    .tile_i (tile_row_q),
    .cell_o (cz),
    .frac_o (fz)
  );

  // Corner addresses wrap at the store size.
  logic [BW-1:0]       base;
  logic [STORE_AW-1:0] raddr [4];
  logic [SAMPLE_W-1:0] y     [4];
  logic                store_we;

  assign base     = BW'(cz) * BW'(EDGE_SAMPLES) + BW'(cx);
  assign raddr[0] = STORE_AW'(base);
  assign raddr[1] = STORE_AW'(base + BW'(1));
  assign raddr[2] = STORE_AW'(base + BW'(EDGE_SAMPLES));
  assign raddr[3] = STORE_AW'(base + BW'(EDGE_SAMPLES) + BW'(1));
  assign store_we = en && v_q[5] && (op_q[5] == OP_WRITE);

  for (genvar g = 0; g < 4; g++) begin : g_store
    hfti_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(STORE_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (store_we),
      .waddr_i(idx_q[5]),
      .wdata_i(val_q[5]),
      .re_i   (en),
      .raddr_i(raddr[g]),
      .rdata_o(y[g])
    );
  end

  // Stage 6: fractions wait beside the store read.
  logic [FB-1:0] fx6_q, fz6_q;

  // Stage 7: triangle select and the two weight products.
  logic                  upper;
  logic [FB:0]           ga, gb;
  logic signed [8:0]     da, db;
  logic [7:0]            yb;
  logic signed [FB+10:0] pa, pb;

  always_comb begin
    upper = ((FB+1)'(fx6_q) + (FB+1)'(fz6_q)) <= ONE;
    if (upper) begin
      ga = (FB+1)'(fx6_q);
      gb = (FB+1)'(fz6_q);
      da = $signed({1'b0, y[1]}) - $signed({1'b0, y[0]});
      db = $signed({1'b0, y[2]}) - $signed({1'b0, y[0]});
      yb = y[0];
    end else begin
      ga = ONE - (FB+1)'(fx6_q);
      gb = ONE - (FB+1)'(fz6_q);
      da = $signed({1'b0, y[2]}) - $signed({1'b0, y[3]});
      db = $signed({1'b0, y[1]}) - $signed({1'b0, y[3]});
      yb = y[3];
    end
    pa = (FB+11)'($signed({1'b0, ga})) * (FB+11)'(da);
    pb = (FB+11)'($signed({1'b0, gb})) * (FB+11)'(db);
  end

  logic                  up_q [7:13];
  logic [7:0]            yb7_q;
  logic signed [FB+10:0] pa7_q, pb7_q;
  logic signed [FB+9:0]  h8_q;
  logic signed [24:0]    d;
  logic signed [FB+34:0] q9_q;
  logic                  neg_q [10:13];
  logic [FB+32:0]        mag10_q;
  logic [16:0]           a11_q;
  logic [15:0]           b11_q;
  logic [35:0]           pa11_q;
  logic [9:0]            qa12, qa12_q, qa13_q;
  logic [7:0]            ra12;
  logic [23:0]           y12_q;
  logic [48:0]           pb13_q;

  assign d    = 25'(max_q) - 25'(min_q);
  assign qa12 = pa11_q[DIV_A_SHIFT +: 10];
  assign ra12 = 8'(a11_q - 17'(qa12) * 17'd255);

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx6_q   <= fx;
      fz6_q   <= fz;
      up_q[7] <= upper;
      yb7_q   <= yb;
      pa7_q   <= pa;
      pb7_q   <= pb;
      for (int k = 8; k <= 13; k++) begin
        up_q[k] <= up_q[k-1];
      end
      // Interpolated height in units of one byte over 2^FRAC_BITS.
      h8_q <= $signed({2'b00, yb7_q, {FB{1'b0}}}) + (FB+10)'(pa7_q) + (FB+10)'(pb7_q);
      q9_q <= (FB+35)'(h8_q) * (FB+35)'(d);
      // Round half away from zero on the magnitude.
      neg_q[10] <= q9_q[FB+34];
      mag10_q   <= (FB+33)'(q9_q[FB+34] ? -q9_q : q9_q) + HALF_DEN;
      for (int k = 11; k <= 13; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      a11_q  <= mag10_q[FB+32:FB+16];
      b11_q  <= mag10_q[FB+15:FB];
      pa11_q <= 36'(mag10_q[FB+32:FB+16]) * 36'(DIV_A_RECIP);
      qa12_q <= qa12;
      y12_q  <= {ra12, b11_q};
      qa13_q <= qa12_q;
      pb13_q <= 49'(y12_q) * 49'(DIV_B_RECIP);
    end
  end

  // Final scale, offset and saturation into the output register.
  logic [26:0]        s14;
  logic signed [27:0] res;
  logic [23:0]        sat;

  always_comb begin
    s14 = 27'({qa13_q, 16'h0000}) + 27'(pb13_q[48:DIV_B_SHIFT]);
    res = 28'(min_q) + (neg_q[13] ? -$signed({1'b0, s14}) : $signed({1'b0, s14}));
    if (res < -28'sd8388608) begin
      sat = 24'h800000;
    end else if (res > 28'sd8388607) begin
      sat = 24'h7FFFFF;
    end else begin
      sat = res[23:0];
    end
  end

  logic [23:0] m_data_q;
  logic        m_upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= v_q[13];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q  <= sat;
      m_upper_q <= up_q[13];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_upper_q;

endmodule

// ----- hdl/hfti_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module hfti_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/hfti_split.sv -----
`timescale 1ns / 1ps
// Five-stage pipeline that turns one Q15.16 coordinate into a grid cell and a fraction.
// Depends on hfti_pkg; divisions by the tile span use reciprocal multiplication.
module hfti_split
  import hfti_pkg::*;
#(
  parameter int unsigned EDGE_SAMPLES = 256,
  parameter int unsigned TILE_SIZE    = 1024,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [31:0]              pos_i,
  input  logic                            world_i,
  input  logic signed [5:0]               tile_i,
  output logic [$clog2(EDGE_SAMPLES)-1:0] cell_o,
  output logic [FRAC_BITS-1:0]            frac_o
);

  localparam int unsigned TW  = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int unsigned LE  = $clog2(EDGE_SAMPLES);
  localparam int unsigned LP  = TW + 16;
  localparam int unsigned NC  = TW + LE;
  localparam int unsigned SC  = NC + TW;
  localparam int unsigned NF  = TW + FRAC_BITS;
  localparam int unsigned SF  = NF + TW;
  localparam int unsigned PCW = 2 * NC + 2;
  localparam int unsigned PFW = 2 * NF + 2;
  localparam longint SPAN = longint'(TILE_SIZE) * 65536;
  localparam logic [63:0] RECIP_C = ((64'd1 << SC) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE);
  localparam logic [63:0] RECIP_F = ((64'd1 << SF) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE);

  logic signed [34:0] org, loc;
  logic [LP-1:0]      p_d, p_q;
  logic [LP+LE-1:0]   num_q;
  logic [NC-1:0]      mx, mx_q;
  logic [15:0]        r16_q;
  logic [PCW-1:0]     pc_q;
  logic [LE-1:0]      cell4, cell4_q, cell5_q;
  logic [TW-1:0]      rm;
  logic [TW+16+FRAC_BITS-1:0] wide;
  logic [NF-1:0]      xf_q;
  logic [PFW-1:0]     pf_q;

  // Tile-local position, clamped into the tile.
  always_comb begin
    org = 35'(tile_i) * 35'(SPAN);
    loc = 35'(pos_i) - (world_i ? org : 35'sd0);
    if (loc < 35'sd0) begin
      p_d = '0;
    end else if (loc >= 35'(SPAN)) begin
      p_d = LP'(SPAN - 1);
    end else begin
      p_d = loc[LP-1:0];
    end
  end

  assign mx    = num_q[LP+LE-1:16];
  assign cell4 = pc_q[SC +: LE];
  assign rm    = TW'(mx_q - NC'(cell4) * NC'(TILE_SIZE));
  assign wide  = {rm, r16_q, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      num_q   <= (LP+LE)'(p_q) * (LP+LE)'(EDGE_SAMPLES - 1);
      pc_q    <= PCW'(mx) * PCW'(RECIP_C);
      mx_q    <= mx;
      r16_q   <= num_q[15:0];
      cell4_q <= cell4;
      xf_q    <= wide[TW+16+FRAC_BITS-1:16];
      pf_q    <= PFW'(xf_q) * PFW'(RECIP_F);
      cell5_q <= cell4_q;
    end
  end

  assign cell_o = cell5_q;
  assign frac_o = pf_q[SF +: FRAC_BITS];

endmodule
